FILE: rtl/mbavg_pkg.sv
package mbavg_pkg;

    localparam int POS_W  = 12;
    localparam int SUM_W  = 18;
    localparam int CH_N   = 4;
    localparam int CNT_W  = 2 * POS_W;
    localparam int CIDX_W = 2;

    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [7:0] channel_3;
        logic [7:0] channel_2;
        logic [7:0] channel_1;
        logic [7:0] channel_0;
    } pix_t;

    typedef struct packed {
        logic [7:0] block_column;
        logic [7:0] block_row;
        logic [4:0] block_width;
        logic [4:0] block_height;
        logic [7:0] average_0;
        logic [7:0] average_1;
        logic [7:0] average_2;
        logic [7:0] average_3;
        logic       frame_done;
    } res_t;

    typedef logic [CH_N-1:0][SUM_W-1:0] sums_t;

    // One completed block handed from the accumulator to the divider.
    typedef struct packed {
        logic [7:0]       block_column;
        logic [7:0]       block_row;
        logic [4:0]       block_width;
        logic [4:0]       block_height;
        logic [CNT_W-1:0] pixel_count;
        sums_t            sums;
        logic [2:0]       channel_count;
        logic             frame_done;
    } job_t;

endpackage

FILE: rtl/mbavg_ram.sv
module mbavg_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mbavg_fifo.sv
module mbavg_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mbavg_pkg::job_t   push_data,
    output logic              full,
    input  logic              pop,
    output mbavg_pkg::job_t   pop_data,
    output logic              empty
);

    mbavg_pkg::job_t mem_reg [2];
    logic            wptr_reg;
    logic            rptr_reg;
    logic [1:0]      cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push && !full) begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop && !empty) begin
                rptr_reg <= ~rptr_reg;
            end
            if ((push && !full) && !(pop && !empty)) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (!(push && !full) && (pop && !empty)) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mbavg_front.sv
module mbavg_front #(
    parameter int BLOCK_SIZE        = 16,
    parameter int MAX_BLOCK_COLUMNS = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mbavg_pkg::pix_t               s_data,
    input  logic [mbavg_pkg::POS_W-1:0]   image_width,
    input  logic [mbavg_pkg::POS_W-1:0]   image_height,
    input  logic [2:0]                    channel_count,
    output logic                          job_push,
    input  logic                          job_full,
    output mbavg_pkg::job_t               job_data
);

    localparam int BLK_W = $clog2(BLOCK_SIZE);
    localparam int BC_W  = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
    localparam int PW    = mbavg_pkg::POS_W;
    localparam int SW    = mbavg_pkg::SUM_W;
    localparam int QSH   = PW + BLK_W;
    localparam int PRW   = QSH + PW;
    localparam logic [BLK_W-1:0] IN_LAST = BLK_W'(BLOCK_SIZE - 1);
    localparam logic [PW-1:0]    STEP    = PW'(BLOCK_SIZE);
    localparam logic [PW-1:0]    MAXC    = PW'(MAX_BLOCK_COLUMNS);
    // ceil(2^QSH / BLOCK_SIZE) gives an exact floor division for any PW-bit extent
    localparam logic [PW:0]      RECIP   =
        (PW + 1)'(((1 << QSH) + BLOCK_SIZE - 1) / BLOCK_SIZE);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_UPD  = 3'b010,
        F_WR   = 3'b100
    } fstate_t;

    fstate_t state_reg;

    // raw position tracking; the block indices are clamped against the config
    logic [PW-1:0]    col_pos_reg, row_pos_reg;
    logic [BLK_W-1:0] col_in_reg, row_in_reg;
    logic [PW-1:0]    ubc_reg, ubr_reg;

    mbavg_pkg::pix_t  pix_reg;
    logic             first_reg, emit_reg, done_reg;
    logic [PW-1:0]    bw_reg, bh_reg;
    logic [7:0]       bc_out_reg, br_out_reg;
    logic [BC_W-1:0]  addr_reg;
    logic [2:0]       cc_reg;
    mbavg_pkg::sums_t sum_reg;
    logic [mbavg_pkg::CNT_W-1:0] count_reg;

    mbavg_pkg::sums_t rd_sums;
    mbavg_pkg::sums_t sum_next;

    logic [PW-1:0]   ew, eh, bw, bh;
    logic [PRW-1:0]  w_prod, h_prod;
    logic [PW-1:0]   w_blk, h_blk, fc_m1, fr_m1, bc, br, cbase, rbase;
    logic [2*PW-1:0] cbase_full, rbase_full;
    logic            last_col, last_row, row_end, frame_end;
    logic            col_blk_end, row_blk_end, accept;

    assign ew        = (image_width == '0) ? PW'(1) : image_width;
    assign eh        = (image_height == '0) ? PW'(1) : image_height;
    assign w_prod    = PRW'(ew) * PRW'(RECIP);
    assign h_prod    = PRW'(eh) * PRW'(RECIP);
    assign w_blk     = w_prod[QSH +: PW];
    assign h_blk     = h_prod[QSH +: PW];
    assign fc_m1     = (w_blk == '0) ? '0 :
                       ((w_blk > MAXC) ? (MAXC - PW'(1)) : (w_blk - PW'(1)));
    assign fr_m1     = (h_blk == '0) ? '0 : (h_blk - PW'(1));
    assign last_col  = (ubc_reg >= fc_m1);
    assign last_row  = (ubr_reg >= fr_m1);
    assign bc        = last_col ? fc_m1 : ubc_reg;
    assign br        = last_row ? fr_m1 : ubr_reg;
    assign cbase_full = {{PW{1'b0}}, bc} * {{PW{1'b0}}, STEP};
    assign rbase_full = {{PW{1'b0}}, br} * {{PW{1'b0}}, STEP};
    assign cbase     = cbase_full[PW-1:0];
    assign rbase     = rbase_full[PW-1:0];
    assign row_end   = ({1'b0, col_pos_reg} + (PW + 1)'(1)) >= {1'b0, ew};
    assign frame_end = ({1'b0, row_pos_reg} + (PW + 1)'(1)) >= {1'b0, eh};
    assign col_blk_end = last_col ? row_end : (col_in_reg == IN_LAST);
    assign row_blk_end = last_row ? frame_end : (row_in_reg == IN_LAST);
    assign bw = last_col ? (ew - cbase) : STEP;
    assign bh = last_row ? (eh - rbase) : STEP;
    assign accept  = s_valid && (state_reg == F_IDLE);
    assign s_ready = (state_reg == F_IDLE);

    mbavg_ram #(
        .WIDTH(mbavg_pkg::CH_N * SW),
        .DEPTH(MAX_BLOCK_COLUMNS)
    ) u_sums (
        .aclk (aclk),
        .we   (state_reg == F_WR),
        .waddr(addr_reg),
        .wdata(sum_reg),
        .raddr(bc[BC_W-1:0]),
        .rdata(rd_sums)
    );

    always_comb begin
        sum_next[0] = (first_reg ? '0 : rd_sums[0]) + SW'(pix_reg.channel_0);
        sum_next[1] = (first_reg ? '0 : rd_sums[1]) + SW'(pix_reg.channel_1);
        sum_next[2] = (first_reg ? '0 : rd_sums[2]) + SW'(pix_reg.channel_2);
        sum_next[3] = (first_reg ? '0 : rd_sums[3]) + SW'(pix_reg.channel_3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            col_in_reg  <= '0;
            row_in_reg  <= '0;
            ubc_reg     <= '0;
            ubr_reg     <= '0;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        state_reg <= F_UPD;
                        if (row_end) begin
                            col_pos_reg <= '0;
                            col_in_reg  <= '0;
                            ubc_reg     <= '0;
                            if (frame_end) begin
                                row_pos_reg <= '0;
                                row_in_reg  <= '0;
                                ubr_reg     <= '0;
                            end else begin
                                row_pos_reg <= row_pos_reg + PW'(1);
                                if (row_in_reg == IN_LAST) begin
                                    row_in_reg <= '0;
                                    ubr_reg    <= ubr_reg + PW'(1);
                                end else begin
                                    row_in_reg <= row_in_reg + BLK_W'(1);
                                end
                            end
                        end else begin
                            col_pos_reg <= col_pos_reg + PW'(1);
                            if (col_in_reg == IN_LAST) begin
                                col_in_reg <= '0;
                                ubc_reg    <= ubc_reg + PW'(1);
                            end else begin
                                col_in_reg <= col_in_reg + BLK_W'(1);
                            end
                        end
                    end
                end
                F_UPD: begin
                    state_reg <= F_WR;
                end
                F_WR: begin
                    // when a block is due, hold until the queue takes it
                    if (!emit_reg || !job_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg    <= s_data;
            first_reg  <= (row_pos_reg == rbase);
            emit_reg   <= col_blk_end && row_blk_end;
            done_reg   <= row_end && frame_end;
            bw_reg     <= bw;
            bh_reg     <= bh;
            bc_out_reg <= bc[7:0];
            br_out_reg <= br[7:0];
            addr_reg   <= bc[BC_W-1:0];
            cc_reg     <= channel_count;
        end
        if (state_reg == F_UPD) begin
            sum_reg   <= sum_next;
            count_reg <= {{PW{1'b0}}, bw_reg} * {{PW{1'b0}}, bh_reg};
        end
    end

    assign job_push = (state_reg == F_WR) && emit_reg && !job_full;

    always_comb begin
        job_data.block_column  = bc_out_reg;
        job_data.block_row     = br_out_reg;
        job_data.block_width   = bw_reg[4:0];
        job_data.block_height  = bh_reg[4:0];
        job_data.pixel_count   = (count_reg == '0) ? mbavg_pkg::CNT_W'(1) : count_reg;
        job_data.sums          = sum_reg;
        job_data.channel_count = cc_reg;
        job_data.frame_done    = done_reg;
    end

endmodule

FILE: rtl/mbavg_back.sv
module mbavg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_empty,
    input  mbavg_pkg::job_t   job_data,
    output logic              job_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mbavg_pkg::res_t   m_data
);

    localparam int SW = mbavg_pkg::SUM_W;
    localparam int CW = mbavg_pkg::CNT_W;
    localparam logic [4:0] STEP_LAST = 5'(SW - 1);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_OUT  = 3'b100
    } bstate_t;

    bstate_t          state_reg;
    mbavg_pkg::job_t  job_reg;
    logic [1:0]       ch_reg;
    logic [4:0]       step_reg;
    logic [SW-1:0]    dvd_reg;
    logic [CW-1:0]    rem_reg;
    logic [7:0]       quo_reg;
    logic [3:0][7:0]  avg_reg;

    logic [CW:0]      rem_sh;
    logic             ge;
    logic [CW-1:0]    rem_next;
    logic [7:0]       quo_next;
    logic             ch_on;

    // one restoring-division bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[SW-1]};
    assign ge       = rem_sh >= {1'b0, job_reg.pixel_count};
    assign rem_next = ge ? CW'(rem_sh - {1'b0, job_reg.pixel_count}) : CW'(rem_sh);
    assign quo_next = {quo_reg[6:0], ge};
    assign ch_on    = ({1'b0, ch_reg} < job_reg.channel_count);

    assign job_pop = (state_reg == B_IDLE) && !job_empty;
    assign m_valid = (state_reg == B_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (!job_empty) begin
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    if ((step_reg == STEP_LAST) && (ch_reg == 2'd3)) begin
                        state_reg <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (m_ready) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg  <= job_data;
            ch_reg   <= 2'd0;
            step_reg <= 5'd0;
            dvd_reg  <= job_data.sums[0];
            rem_reg  <= '0;
            quo_reg  <= '0;
        end else if (state_reg == B_DIV) begin
            if (step_reg == STEP_LAST) begin
                avg_reg[ch_reg] <= ch_on ? quo_next : 8'd0;
                ch_reg   <= ch_reg + 2'd1;
                step_reg <= 5'd0;
                dvd_reg  <= job_reg.sums[ch_reg + 2'd1];
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else begin
                step_reg <= step_reg + 5'd1;
                dvd_reg  <= {dvd_reg[SW-2:0], 1'b0};
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
            end
        end
    end

    always_comb begin
        m_data.block_column = job_reg.block_column;
        m_data.block_row    = job_reg.block_row;
        m_data.block_width  = job_reg.block_width;
        m_data.block_height = job_reg.block_height;
        m_data.average_0    = avg_reg[0];
        m_data.average_1    = avg_reg[1];
        m_data.average_2    = avg_reg[2];
        m_data.average_3    = avg_reg[3];
        m_data.frame_done   = job_reg.frame_done;
    end

endmodule

FILE: rtl/block_mosaic_averager.sv
// A pixel is taken through a read, an add and a write of the column-sum RAM.
// A block result shows on m_valid after its last pixel is accepted: queue hop,
// then four serial divisions, one per channel.
// A pixel is not accepted until the last one is written back; results are held until m_ready.
// Reset (aresetn low, synchronous) clears position counters, queue and config
// to 16x16 with 3 channels; the column-sum RAM is not cleared.
module block_mosaic_averager #(
    parameter int BLOCK_SIZE        = 16,
    parameter int MAX_BLOCK_COLUMNS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mbavg_pkg::pix_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mbavg_pkg::res_t                m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mbavg_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [mbavg_pkg::POS_W-1:0]    cfg_data
);

    logic [mbavg_pkg::POS_W-1:0] width_reg, height_reg;
    logic [2:0]                  chan_reg;

    logic            job_push, job_full, job_pop, job_empty;
    mbavg_pkg::job_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mbavg_pkg::POS_W'(16);
            height_reg <= mbavg_pkg::POS_W'(16);
            chan_reg   <= 3'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mbavg_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                mbavg_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                mbavg_pkg::REG_CHANNEL_COUNT: chan_reg   <= cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    mbavg_front #(
        .BLOCK_SIZE       (BLOCK_SIZE),
        .MAX_BLOCK_COLUMNS(MAX_BLOCK_COLUMNS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .image_width  (width_reg),
        .image_height (height_reg),
        .channel_count(chan_reg),
        .job_push     (job_push),
        .job_full     (job_full),
        .job_data     (push_data)
    );

    mbavg_fifo u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_data(push_data),
        .full     (job_full),
        .pop      (job_pop),
        .pop_data (pop_data),
        .empty    (job_empty)
    );

    mbavg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_empty(job_empty),
        .job_data (pop_data),
        .job_pop  (job_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

FILE: rtl/mbavg_checker.sv
module mbavg_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input logic            m_valid,
    input logic            m_ready,
    input mbavg_pkg::res_t m_data
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // each pixel needs a read-add-write pass before the next transfer
    a_pixel_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel accepted on consecutive cycles");

    // the divider must finish a new job before the next result
    a_result_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("results on consecutive cycles");

endmodule

bind block_mosaic_averager mbavg_checker u_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
